// ===== rtl/uuenc_pkg.sv =====
// Shared types and the character mapping for the uuencode line encoder.
// No dependencies; imported by uuenc_out_stage and the top level.
package uuenc_pkg;

    localparam logic [6:0] CHAR_SPACE     = 7'd32;
    localparam logic [6:0] CHAR_BACKQUOTE = 7'd96;

    // One 6-bit value on its way to the output register, with the end-of-line mark.
    typedef struct packed {
        logic [5:0] value;
        logic       last;
    } sextet_t;

    // A zero value would be a space, which trailing-space stripping can eat,
    // so it is sent as a backquote instead.
    function automatic logic [6:0] uu_char(input logic [5:0] value);
        logic [6:0] ch;
        if (value == 6'd0)
        begin
            ch = CHAR_BACKQUOTE;
        end
        else
        begin
            ch = {1'b0, value} + CHAR_SPACE;
        end
        return ch;
    endfunction

endpackage

// ===== rtl/uuenc_out_stage.sv =====
// Output register of the uuencode line encoder: maps 6-bit values to ASCII.
// Depends on uuenc_pkg for sextet_t and uu_char.
module uuenc_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  uuenc_pkg::sextet_t sextet,
    output logic               free,
    output logic               char_valid,
    input  logic               char_stall,
    output logic [6:0]         text_char,
    output logic               line_end
);
    import uuenc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [6:0] char_reg;
    logic       end_reg;

    // The register can take a new character when it is empty or being drained.
    assign free = !valid_reg || !char_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            char_reg <= uu_char(sextet.value);
            end_reg  <= sextet.last;
        end
    end

    assign char_valid = valid_reg;
    assign text_char  = char_reg;
    assign line_end   = end_reg;

endmodule

// ===== rtl/uuencode_line_encoder_unit.sv =====
// Top level of the uuencode line encoder: line memory, fill count and line sequencer.
// Depends on uuenc_pkg and uuenc_out_stage.
//
// Bytes are taken one per cycle while a line is being gathered and written into
// a LINE_BYTES-entry line memory. When the line fills, or a byte flagged final
// arrives, the block stops taking bytes and streams the line: a length character,
// then four characters per group of three bytes, one character per cycle while
// the output is not stalled. The memory's single read port, prefetched one byte
// ahead, feeds that stream. A short last group is padded with zeros, never with
// stale memory contents. There is no clearing pass after reset; the block accepts
// bytes from the first cycle.
module uuencode_line_encoder_unit #(
    parameter int LINE_BYTES = 45
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [6:0] text_char,
    output logic       line_end
);
    import uuenc_pkg::*;

    localparam int CNT_W  = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W = $clog2(LINE_BYTES);
    localparam int IDX_W  = CNT_W + 1;

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_LEN     = 2'd1;
    localparam logic [1:0] ST_DATA    = 2'd2;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;
    localparam logic [1:0] PH_FOURTH = 2'd3;

    logic [7:0] line_mem [LINE_BYTES];

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] base_reg;
    logic [CNT_W-1:0] base_next;
    logic [7:0]       prev_reg;
    logic [7:0]       prev_next;
    logic [7:0]       rd_data_reg;
    logic             pad_reg;

    logic             byte_accept;
    logic             out_free;
    logic             out_load;
    sextet_t          sextet;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_pad;
    logic [CNT_W-1:0] fill_inc;
    logic [IDX_W-1:0] base_wide;
    logic [IDX_W-1:0] next_base;
    logic [7:0]       cur_byte;

    assign byte_stall  = (state_reg != ST_COLLECT);
    assign byte_accept = byte_valid && !byte_stall;
    assign fill_inc    = fill_reg + CNT_W'(1);
    assign base_wide   = {1'b0, base_reg};
    assign next_base   = base_wide + IDX_W'(3);
    assign cur_byte    = pad_reg ? 8'd0 : rd_data_reg;
    assign rd_pad      = (rd_idx >= {1'b0, fill_reg});

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        base_next    = base_reg;
        prev_next    = prev_reg;
        out_load     = 1'b0;
        sextet.value = 6'd0;
        sextet.last  = 1'b0;
        rd_en        = 1'b0;
        rd_idx       = base_wide;
        case (state_reg)
            ST_COLLECT:
            begin
                if (byte_accept)
                begin
                    fill_next = fill_inc;
                    if (final_byte || (fill_inc == CNT_W'(LINE_BYTES)))
                    begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                sextet.value = 6'(fill_reg);
                if (out_free)
                begin
                    out_load   = 1'b1;
                    rd_en      = 1'b1;
                    rd_idx     = '0;
                    base_next  = '0;
                    phase_next = PH_FIRST;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        sextet.value = cur_byte[7:2];
                        rd_idx       = base_wide + IDX_W'(1);
                    end
                    PH_SECOND:
                    begin
                        sextet.value = {prev_reg[1:0], cur_byte[7:4]};
                        rd_idx       = base_wide + IDX_W'(2);
                    end
                    PH_THIRD:
                    begin
                        sextet.value = {prev_reg[3:0], cur_byte[7:6]};
                    end
                    PH_FOURTH:
                    begin
                        sextet.value = prev_reg[5:0];
                        sextet.last  = (next_base >= {1'b0, fill_reg});
                        rd_idx       = next_base;
                    end
                    default:
                    begin
                        sextet.value = 6'd0;
                    end
                endcase
                if (out_free)
                begin
                    out_load   = 1'b1;
                    prev_next  = cur_byte;
                    phase_next = phase_reg + 2'd1;
                    // Each byte is fetched while the character before it goes out.
                    if (phase_reg == PH_FIRST || phase_reg == PH_SECOND)
                    begin
                        rd_en = 1'b1;
                    end
                    if (phase_reg == PH_FOURTH)
                    begin
                        if (sextet.last)
                        begin
                            fill_next  = '0;
                            state_next = ST_COLLECT;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            base_next = next_base[CNT_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            phase_reg <= PH_FIRST;
            fill_reg  <= '0;
            base_reg  <= '0;
            pad_reg   <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            base_reg  <= base_next;
            if (rd_en)
            begin
                pad_reg <= rd_pad;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

    // Line memory: one write port for incoming bytes, one registered read port.
    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            line_mem[fill_reg[ADDR_W-1:0]] <= data_byte;
        end
        if (rd_en && !rd_pad)
        begin
            rd_data_reg <= line_mem[rd_idx[ADDR_W-1:0]];
        end
    end

    uuenc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .sextet     (sextet),
        .free       (out_free),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .text_char  (text_char),
        .line_end   (line_end)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(LINE_BYTES))
        else $error("fill count exceeds the line length");

    a_len_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN) |-> (fill_reg != '0))
        else $error("length character started for an empty line");

    a_group_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (base_reg < fill_reg))
        else $error("group base ran past the held byte count");

    // A stalled line end may still be waiting while the next line is gathered.
    a_end_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && line_end) |-> (state_reg != ST_DATA))
        else $error("line end shown while the line is still being sent");

endmodule

// ===== sim/uuencode_line_encoder_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for uuencode_line_encoder_unit: byte streams go in and every
// encoded character is compared with a line-by-line prediction kept in the bench.
// Depends on the RTL top level and uuenc_pkg only.
module uuencode_line_encoder_unit_tb;

    import uuenc_pkg::*;

    localparam int          LINE_BYTES  = 45;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        logic [6:0] code;
        logic       eol;
    } uu_text_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       byte_valid = 1'b0;
    logic [7:0] data_byte  = 8'h00;
    logic       final_byte = 1'b0;
    logic       char_stall = 1'b0;
    logic       byte_stall;
    logic       char_valid;
    logic [6:0] text_char;
    logic       line_end;

    // Bytes of the line being gathered and the characters still owed by the block.
    logic [7:0]  line_buf [0:LINE_BYTES-1];
    int unsigned held_count = 0;
    uu_text_t    expected_chars [$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_busy_pct  = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned lines_seen   = 0;
    int unsigned chars_checked = 0;

    uuencode_line_encoder_unit #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .data_byte (data_byte),
        .final_byte(final_byte),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .text_char (text_char),
        .line_end  (line_end)
    );

    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_length();
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(40, 12);
        end
        return $urandom_range(3, 1);
    endfunction

    // Random byte, weighted toward the all-zero and all-one extremes.
    function automatic logic [7:0] pick_byte();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return 8'h00;
        end
        if (sel == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [6:0] sextet_to_text(input logic [5:0] v);
        if (v == 6'd0)
        begin
            return CHAR_BACKQUOTE;
        end
        return {1'b0, v} + CHAR_SPACE;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    // Adds one byte to the predicted line and queues the characters of a finished line.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        int         g;
        int         n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        if (held_count < LINE_BYTES)
        begin
            line_buf[held_count] = b;
            held_count++;
        end
        if (held_count < LINE_BYTES && !fin)
        begin
            return;
        end
        n = held_count;
        expected_chars.push_back('{sextet_to_text(6'(n)), 1'b0});
        for (g = 0; g < n; g += 3)
        begin
            // Positions past the held count are zero, whatever the store still holds.
            b0 = line_buf[g];
            b1 = (g + 1 < n) ? line_buf[g + 1] : 8'h00;
            b2 = (g + 2 < n) ? line_buf[g + 2] : 8'h00;
            expected_chars.push_back('{sextet_to_text(b0[7:2]), 1'b0});
            expected_chars.push_back('{sextet_to_text({b0[1:0], b1[7:4]}), 1'b0});
            expected_chars.push_back('{sextet_to_text({b1[3:0], b2[7:6]}), 1'b0});
            expected_chars.push_back('{sextet_to_text(b2[5:0]), g + 3 >= n});
        end
        held_count = 0;
        lines_seen++;
    endtask

    // Offers one byte, waits for the transaction and then maybe leaves a gap.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        byte_valid <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        do @(posedge clk); while (byte_stall);
        encode_byte(b, fin);
        bytes_sent++;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            byte_valid <= 1'b0;
            repeat (idle_length()) @(posedge clk);
        end
    endtask

    task automatic send_stream(input int unsigned len);
        int unsigned i;
        for (i = 1; i <= len; i++)
        begin
            send_byte(pick_byte(), i == len);
        end
    endtask

    task automatic drain_lines();
        byte_valid <= 1'b0;
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        // A full line is 61 characters: the length character and four per group of three bytes.
        repeat (150) @(posedge clk);
    endtask

    task automatic test_short_lines();
        tx_idle_pct = 0;
        rx_busy_pct = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFC, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h7E, 1'b1);
        drain_lines();
    endtask

    task automatic test_full_lines();
        int unsigned i;
        tx_idle_pct = 20;
        rx_busy_pct = 20;
        // A full line without a final flag, then one that ends exactly on the final byte.
        for (i = 0; i < LINE_BYTES; i++)
        begin
            send_byte(pick_byte(), 1'b0);
        end
        send_stream(LINE_BYTES);
        // A short line right after a full one must be padded with zeros, not old bytes.
        send_stream(2);
        send_stream(LINE_BYTES + 1);
        drain_lines();
    endtask

    task automatic test_receiver_hold();
        tx_idle_pct = 0;
        rx_busy_pct = 0;
        hold_request = HOLD_CYCLES;
        send_stream(50);
        send_stream(10);
        drain_lines();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        int unsigned sent;
        int unsigned len;
        int unsigned i;
        tx_idle_pct = tx_pct;
        rx_busy_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(4) != 0)
            begin
                case ($urandom_range(9))
                    0: len = LINE_BYTES;
                    1: len = 2 * LINE_BYTES;
                    2: len = LINE_BYTES - 1 + $urandom_range(2);
                    default: len = $urandom_range(30, 1);
                endcase
                send_stream(len);
                sent += len;
            end
            else
            begin
                // Loose bytes with the final flag set at random.
                for (i = 0; i < 8; i++)
                begin
                    send_byte(pick_byte(), $urandom_range(7) == 0);
                end
                sent += 8;
            end
        end
        send_byte(pick_byte(), 1'b1);
        drain_lines();
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            char_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left != 0)
        begin
            char_stall <= 1'b1;
            stall_left--;
        end
        else if (rx_busy_pct != 0 && $urandom_range(99) < rx_busy_pct)
        begin
            char_stall <= 1'b1;
            stall_left = idle_length() - 1;
        end
        else
        begin
            char_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        uu_text_t want;
        if (rst_n && char_valid && !char_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %0d, line_end %0b",
                                          text_char, line_end));
            end
            else
            begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (text_char !== want.code)
                begin
                    report_mismatch($sformatf("text_char %0d, expected %0d",
                                              text_char, want.code));
                end
                if (line_end !== want.eol)
                begin
                    report_mismatch($sformatf("line_end %0b, expected %0b",
                                              line_end, want.eol));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_chars.size());
            $display("FAIL uuencode_line_encoder_unit");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_lines();
        test_full_lines();
        test_receiver_hold();
        test_random_traffic(25, 0, 0);
        test_random_traffic(25, 25, 25);
        test_random_traffic(25, 10, 50);
        if (expected_chars.size() != 0)
        begin
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        end
        $display("Sent %0d bytes forming %0d lines; checked %0d characters.",
                 bytes_sent, lines_seen, chars_checked);
        $display("Covered short and full lines, padding, a %0d-cycle output hold-off and idling.",
                 HOLD_CYCLES);
        if (error_count == 0)
        begin
            $display("PASS uuencode_line_encoder_unit");
        end
        else
        begin
            $display("FAIL uuencode_line_encoder_unit");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/uuenc_pkg.sv
rtl/uuenc_out_stage.sv
rtl/uuencode_line_encoder_unit.sv
sim/uuencode_line_encoder_unit_tb.sv
